// ===== design/btuh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btuh_pkg
// Types and codes shared by the upstream board-transfer handshake block.
// ----------------------------------------------------------------------------
package btuh_pkg;

  typedef enum logic [3:0] {
    ST_NOTCONN  = 4'd0,
    ST_SOCKET   = 4'd1,
    ST_SVCDESC  = 4'd2,
    ST_IDLE     = 4'd3,
    ST_AVAIL    = 4'd4,
    ST_READY    = 4'd5,
    ST_AVRDY    = 4'd6,
    ST_TRANSP   = 4'd7,
    ST_STOPPED  = 4'd8,
    ST_FINISHED = 4'd9,
    ST_DISC     = 4'd10
  } state_t;

  localparam logic [4:0] OP_L_SVCDESC    = 5'd0;
  localparam logic [4:0] OP_L_READY      = 5'd1;
  localparam logic [4:0] OP_L_REVOKE     = 5'd2;
  localparam logic [4:0] OP_L_START      = 5'd3;
  localparam logic [4:0] OP_L_STOP       = 5'd4;
  localparam logic [4:0] OP_L_QUERY      = 5'd5;
  localparam logic [4:0] OP_L_NOTIFY     = 5'd6;
  localparam logic [4:0] OP_L_COMMAND    = 5'd7;
  localparam logic [4:0] OP_L_ALIVE      = 5'd8;
  localparam logic [4:0] OP_L_DISCONNECT = 5'd9;
  localparam logic [4:0] OP_P_CONNECT    = 5'd10;
  localparam logic [4:0] OP_P_SVCDESC    = 5'd11;
  localparam logic [4:0] OP_P_AVAIL      = 5'd12;
  localparam logic [4:0] OP_P_REVOKE     = 5'd13;
  localparam logic [4:0] OP_P_FINISHED   = 5'd14;
  localparam logic [4:0] OP_P_FORECAST   = 5'd15;
  localparam logic [4:0] OP_P_BOARDINFO  = 5'd16;
  localparam logic [4:0] OP_P_NOTIFY     = 5'd17;
  localparam logic [4:0] OP_P_COMMAND    = 5'd18;
  localparam logic [4:0] OP_P_ALIVE      = 5'd19;
  localparam logic [4:0] OP_P_DISCONN    = 5'd20;

  localparam logic [2:0] RK_NONE    = 3'd0;
  localparam logic [2:0] RK_STATE   = 3'd1;
  localparam logic [2:0] RK_SOCKET  = 3'd2;
  localparam logic [2:0] RK_DELIVER = 3'd3;
  localparam logic [2:0] RK_DISC    = 3'd4;

  localparam logic [1:0] FN_NONE     = 2'd0;
  localparam logic [1:0] FN_SOFTWARE = 2'd1;
  localparam logic [1:0] FN_PROTOCOL = 2'd2;

  localparam logic [1:0] EC_NONE   = 2'd0;
  localparam logic [1:0] EC_CLIENT = 2'd1;
  localparam logic [1:0] EC_PEER   = 2'd2;
  localparam logic [1:0] EC_WARN   = 2'd3;

  typedef struct packed {
    state_t      state;
    logic [63:0] start_id;
    logic        start_id_valid;
  } ctx_t;

  typedef struct packed {
    state_t     new_state;
    logic [2:0] report_kind;
    logic       forward_message;
    logic       forward_disconnect;
    logic [1:0] fatal_notice;
    logic [1:0] error_class;
    logic       id_mismatch;
  } result_t;

endpackage
`default_nettype wire

// ===== design/btuh_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btuh_step
// Transition logic: one event against the current handshake context gives
// the next context and the result word.
// ----------------------------------------------------------------------------
module btuh_step
  import btuh_pkg::*;
(
  input  wire logic        strict_check,
  input  wire logic [4:0]  operation,
  input  wire logic [63:0] board_id,
  input  wire logic        raw_forward,
  input  wire ctx_t        cur,
  output ctx_t             nxt,
  output result_t          res
);

  always_comb begin
    logic   is_local;
    logic   legal;
    logic   peer_bad;
    state_t target;
    state_t s;
    logic   dead;

    s        = cur.state;
    dead     = (s == ST_NOTCONN) || (s == ST_DISC);
    is_local = 1'b0;
    legal    = 1'b0;
    peer_bad = 1'b0;
    target   = s;
    nxt      = cur;
    res      = '0;

    unique case (operation)
      OP_L_SVCDESC: begin
        is_local = 1'b1;
        legal    = (s == ST_SOCKET);
        target   = ST_SVCDESC;
      end
      OP_L_READY: begin
        is_local = 1'b1;
        legal    = (s == ST_IDLE) || (s == ST_AVAIL);
        target   = (s == ST_IDLE) ? ST_READY : ST_AVRDY;
      end
      OP_L_REVOKE: begin
        is_local = 1'b1;
        legal    = (s == ST_READY) || (s == ST_AVRDY);
        target   = (s == ST_READY) ? ST_IDLE : ST_AVAIL;
      end
      OP_L_START: begin
        is_local = 1'b1;
        legal    = (s == ST_AVRDY) || (s == ST_READY);
        target   = ST_TRANSP;
      end
      OP_L_STOP: begin
        is_local = 1'b1;
        legal    = (s == ST_TRANSP) || (s == ST_FINISHED);
        target   = (s == ST_TRANSP) ? ST_STOPPED : ST_IDLE;
      end
      OP_L_QUERY, OP_L_NOTIFY, OP_L_COMMAND, OP_L_ALIVE: begin
        res.forward_message = !dead;
      end
      OP_L_DISCONNECT: begin
        if (s != ST_DISC) begin
          nxt.state              = ST_DISC;
          res.report_kind        = RK_STATE;
          res.forward_disconnect = 1'b1;
        end
      end
      OP_P_CONNECT: begin
        if (s == ST_NOTCONN) begin
          nxt.state       = ST_SOCKET;
          res.report_kind = RK_SOCKET;
        end else begin
          peer_bad = 1'b1;
        end
      end
      OP_P_SVCDESC: begin
        if (s == ST_SVCDESC) begin
          nxt.state       = ST_IDLE;
          res.report_kind = RK_DELIVER;
        end else begin
          peer_bad = 1'b1;
        end
      end
      OP_P_AVAIL: begin
        if (s == ST_IDLE || s == ST_READY) begin
          nxt.state       = (s == ST_IDLE) ? ST_AVAIL : ST_AVRDY;
          res.report_kind = RK_DELIVER;
        end else begin
          peer_bad = (s != ST_TRANSP) && (s != ST_STOPPED);
        end
      end
      OP_P_REVOKE: begin
        if (s == ST_AVAIL || s == ST_AVRDY) begin
          nxt.state       = (s == ST_AVAIL) ? ST_IDLE : ST_READY;
          res.report_kind = RK_DELIVER;
        end else begin
          peer_bad = (s != ST_TRANSP) && (s != ST_STOPPED);
        end
      end
      OP_P_FINISHED: begin
        if (s == ST_STOPPED || s == ST_TRANSP) begin
          if (cur.start_id_valid && (board_id != cur.start_id)) begin
            res.id_mismatch = 1'b1;
            peer_bad        = 1'b1;
          end else begin
            nxt.state       = (s == ST_STOPPED) ? ST_IDLE : ST_FINISHED;
            res.report_kind = RK_DELIVER;
          end
        end else begin
          peer_bad = 1'b1;
        end
      end
      OP_P_FORECAST: begin
        if (s == ST_IDLE || s == ST_READY) begin
          res.report_kind = RK_DELIVER;
        end else begin
          peer_bad = (s != ST_TRANSP) && (s != ST_STOPPED);
        end
      end
      OP_P_BOARDINFO, OP_P_NOTIFY, OP_P_COMMAND, OP_P_ALIVE: begin
        res.report_kind = dead ? RK_NONE : RK_DELIVER;
      end
      OP_P_DISCONN: begin
        if (s != ST_DISC) begin
          nxt.state       = ST_DISC;
          res.report_kind = RK_DISC;
        end
      end
      default: begin
      end
    endcase

    if (is_local) begin
      if (legal) begin
        nxt.state           = target;
        res.report_kind     = RK_STATE;
        res.forward_message = 1'b1;
        if (operation == OP_L_START) begin
          nxt.start_id_valid = !raw_forward;
          nxt.start_id       = raw_forward ? 64'd0 : board_id;
        end
      end else if (strict_check) begin
        res.error_class = EC_CLIENT;
        if (s != ST_DISC) begin
          res.fatal_notice       = (s != ST_NOTCONN) ? FN_SOFTWARE : FN_NONE;
          nxt.state              = ST_DISC;
          res.report_kind        = RK_DISC;
          res.forward_disconnect = 1'b1;
        end
      end else begin
        res.error_class     = EC_WARN;
        res.forward_message = 1'b1;
        if (operation == OP_L_START) begin
          nxt.start_id_valid = 1'b0;
          nxt.start_id       = 64'd0;
        end
      end
    end

    if (peer_bad) begin
      res.error_class = EC_PEER;
      if (s != ST_DISC) begin
        nxt.state              = ST_DISC;
        res.report_kind        = RK_DISC;
        res.fatal_notice       = FN_PROTOCOL;
        res.forward_disconnect = 1'b1;
      end
    end

    res.new_state = nxt.state;
  end

endmodule
`default_nettype wire

// ===== design/board_transfer_upstream_handshake.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// board_transfer_upstream_handshake
// Upstream side of the board-transfer handshake: one event word in, one
// result word out, eleven-state protocol state and recorded start id.
// ----------------------------------------------------------------------------
//  channel  signals                         handshake
//  event    operation board_id raw_forward  event_valid / event_stall
//  result   new_state ... id_mismatch       result_valid / result_stall
//  cfg      cfg_data (strict_check)         cfg_valid / cfg_ready
//
//  An event word lands in a holding register, and its result is written to
//  the result register once that register is free.
//  One word per cycle is sustained while result_stall is low; the state update sits in the single
//  transition stage between the holding and result registers.
//  The holding register keeps taking words while the result waits, until
//  both are full; then event_stall follows result_stall.
//  Synchronous reset: state notconn, no start id, strict_check set.
// ----------------------------------------------------------------------------
module board_transfer_upstream_handshake
  import btuh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        event_valid,
  output logic             event_stall,
  input  wire logic [4:0]  operation,
  input  wire logic [63:0] board_id,
  input  wire logic        raw_forward,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [3:0]       new_state,
  output logic [2:0]       report_kind,
  output logic             forward_message,
  output logic             forward_disconnect,
  output logic [1:0]       fatal_notice,
  output logic [1:0]       error_class,
  output logic             id_mismatch,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  logic        strict_check;
  logic        hold_valid;
  logic [4:0]  hold_op;
  logic [63:0] hold_bid;
  logic        hold_raw;
  ctx_t        ctx;
  ctx_t        ctx_next;
  result_t     result;
  result_t     result_next;
  logic        out_free;
  logic        advance;
  logic        accept;

  assign cfg_ready   = 1'b1;
  assign out_free    = !result_valid || !result_stall;
  assign advance     = hold_valid && out_free;
  assign event_stall = hold_valid && !out_free;
  assign accept      = event_valid && !event_stall;

  btuh_step u_step (
    .strict_check (strict_check),
    .operation    (hold_op),
    .board_id     (hold_bid),
    .raw_forward  (hold_raw),
    .cur          (ctx),
    .nxt          (ctx_next),
    .res          (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_check <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      strict_check <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op  <= operation;
      hold_bid <= board_id;
      hold_raw <= raw_forward;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state          <= ST_NOTCONN;
      ctx.start_id       <= 64'd0;
      ctx.start_id_valid <= 1'b0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign new_state          = result.new_state;
  assign report_kind        = result.report_kind;
  assign forward_message    = result.forward_message;
  assign forward_disconnect = result.forward_disconnect;
  assign fatal_notice       = result.fatal_notice;
  assign error_class        = result.error_class;
  assign id_mismatch        = result.id_mismatch;

`ifndef SYNTH
  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (ctx.state == result.new_state))
    else $error("protocol state differs from the state in the result word");

  a_fatal_disc: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (fatal_notice != FN_NONE)) |-> (new_state == ST_DISC))
    else $error("fatal notice without disconnected state");

  a_mismatch_peer: assert property (@(posedge clk) disable iff (rst)
    (result_valid && id_mismatch) |-> (error_class == EC_PEER))
    else $error("id mismatch not classed as peer error");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    event_stall |-> (hold_valid && result_valid))
    else $error("event stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire

// ===== dv/btuh_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btuh_result_checker
// Watches the event, result and config channels of the upstream handshake
// block. Every accepted event word is run through a local copy of the
// handshake state machine. The expected result word is queued, and each
// accepted result word is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module btuh_result_checker
  import btuh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        event_valid,
  input  logic        event_stall,
  input  logic [4:0]  operation,
  input  logic [63:0] board_id,
  input  logic        raw_forward,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [3:0]  new_state,
  input  logic [2:0]  report_kind,
  input  logic        forward_message,
  input  logic        forward_disconnect,
  input  logic [1:0]  fatal_notice,
  input  logic [1:0]  error_class,
  input  logic        id_mismatch,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          errors,
  output int          pending
);

  state_t      hs_state;
  logic [63:0] tag_id;
  logic        tag_valid;
  logic        strict_mode;
  result_t     expected_words[$];

  // Returns 1 when the illegal local event is tolerated and forwarded.
  function automatic logic tolerate_local(inout result_t r);
    if (!strict_mode) begin
      r.error_class = EC_WARN;
      return 1'b1;
    end
    r.error_class = EC_CLIENT;
    if (hs_state != ST_DISC) begin
      if (hs_state != ST_NOTCONN) r.fatal_notice = FN_SOFTWARE;
      hs_state = ST_DISC;
      r.report_kind = RK_DISC;
      r.forward_disconnect = 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void peer_refused(inout result_t r);
    r.error_class = EC_PEER;
    if (hs_state != ST_DISC) begin
      hs_state = ST_DISC;
      r.report_kind = RK_DISC;
      r.fatal_notice = FN_PROTOCOL;
      r.forward_disconnect = 1'b1;
    end
  endfunction

  function automatic void local_move(inout result_t r, input state_t to);
    hs_state = to;
    r.report_kind = RK_STATE;
    r.forward_message = 1'b1;
  endfunction

  function automatic void peer_move(inout result_t r, input state_t to);
    hs_state = to;
    r.report_kind = RK_DELIVER;
  endfunction

  function automatic result_t step_handshake(input logic [4:0] op, input logic [63:0] bid,
                                             input logic raw);
    result_t r;
    state_t  s;
    logic    dead;
    r = '0;
    s = hs_state;
    dead = (s == ST_NOTCONN) || (s == ST_DISC);
    case (op)
      OP_L_SVCDESC:
        if (s == ST_SOCKET) local_move(r, ST_SVCDESC);
        else if (tolerate_local(r)) r.forward_message = 1'b1;
      OP_L_READY:
        if (s == ST_IDLE) local_move(r, ST_READY);
        else if (s == ST_AVAIL) local_move(r, ST_AVRDY);
        else if (tolerate_local(r)) r.forward_message = 1'b1;
      OP_L_REVOKE:
        if (s == ST_READY) local_move(r, ST_IDLE);
        else if (s == ST_AVRDY) local_move(r, ST_AVAIL);
        else if (tolerate_local(r)) r.forward_message = 1'b1;
      OP_L_START:
        if (s == ST_AVRDY || s == ST_READY) begin
          tag_valid = !raw;
          tag_id = raw ? '0 : bid;
          local_move(r, ST_TRANSP);
        end else if (tolerate_local(r)) begin
          tag_valid = 1'b0;
          tag_id = '0;
          r.forward_message = 1'b1;
        end
      OP_L_STOP:
        if (s == ST_TRANSP) local_move(r, ST_STOPPED);
        else if (s == ST_FINISHED) local_move(r, ST_IDLE);
        else if (tolerate_local(r)) r.forward_message = 1'b1;
      OP_L_QUERY, OP_L_NOTIFY, OP_L_COMMAND, OP_L_ALIVE:
        if (!dead) r.forward_message = 1'b1;
      OP_L_DISCONNECT:
        if (s != ST_DISC) begin
          hs_state = ST_DISC;
          r.report_kind = RK_STATE;
          r.forward_disconnect = 1'b1;
        end
      OP_P_CONNECT:
        if (s == ST_NOTCONN) begin
          hs_state = ST_SOCKET;
          r.report_kind = RK_SOCKET;
        end else peer_refused(r);
      OP_P_SVCDESC:
        if (s == ST_SVCDESC) peer_move(r, ST_IDLE);
        else peer_refused(r);
      OP_P_AVAIL:
        if (s == ST_IDLE) peer_move(r, ST_AVAIL);
        else if (s == ST_READY) peer_move(r, ST_AVRDY);
        else if (s != ST_TRANSP && s != ST_STOPPED) peer_refused(r);
      OP_P_REVOKE:
        if (s == ST_AVAIL) peer_move(r, ST_IDLE);
        else if (s == ST_AVRDY) peer_move(r, ST_READY);
        else if (s != ST_TRANSP && s != ST_STOPPED) peer_refused(r);
      OP_P_FINISHED:
        if (s == ST_STOPPED || s == ST_TRANSP) begin
          if (tag_valid && bid != tag_id) begin
            r.id_mismatch = 1'b1;
            peer_refused(r);
          end else peer_move(r, (s == ST_STOPPED) ? ST_IDLE : ST_FINISHED);
        end else peer_refused(r);
      OP_P_FORECAST:
        if (s == ST_IDLE || s == ST_READY) r.report_kind = RK_DELIVER;
        else if (s != ST_TRANSP && s != ST_STOPPED) peer_refused(r);
      OP_P_BOARDINFO, OP_P_NOTIFY, OP_P_COMMAND, OP_P_ALIVE:
        if (!dead) r.report_kind = RK_DELIVER;
      OP_P_DISCONN:
        if (s != ST_DISC) begin
          hs_state = ST_DISC;
          r.report_kind = RK_DISC;
        end
      default: ;
    endcase
    r.new_state = hs_state;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      hs_state = ST_NOTCONN;
      tag_id = '0;
      tag_valid = 1'b0;
      strict_mode = 1'b1;
      expected_words.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) strict_mode = cfg_data;
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with no expectation, expected none, actual state %0d",
                   $time, new_state);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("new_state", want.new_state, new_state);
          check_field("report_kind", 4'(want.report_kind), 4'(report_kind));
          check_field("forward_message", 4'(want.forward_message), 4'(forward_message));
          check_field("forward_disconnect", 4'(want.forward_disconnect),
                      4'(forward_disconnect));
          check_field("fatal_notice", 4'(want.fatal_notice), 4'(fatal_notice));
          check_field("error_class", 4'(want.error_class), 4'(error_class));
          check_field("id_mismatch", 4'(want.id_mismatch), 4'(id_mismatch));
        end
      end
      if (event_valid && !event_stall)
        expected_words.push_back(step_handshake(operation, board_id, raw_forward));
      pending = expected_words.size();
    end
  end

endmodule

// ===== dv/tb_board_transfer_upstream_handshake.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_board_transfer_upstream_handshake
// Drives event words into the upstream handshake block: a directed walk
// through the handshake, then long random sessions of legal moves mixed
// with pass-through, unused and tolerated illegal events, and finally one
// session-ending event followed by noise in the disconnected state. Both
// channels idle at random. The checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_board_transfer_upstream_handshake;
  import btuh_pkg::*;

  localparam int         IDLE_LIMIT    = 1000;
  localparam int         SETTLE_CYCLES = 4;
  localparam logic [4:0] OP_UNUSED_LO  = 5'd21;
  localparam logic [4:0] OP_UNUSED_HI  = 5'd31;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        event_valid = 1'b0;
  logic        event_stall;
  logic [4:0]  operation = '0;
  logic [63:0] board_id = '0;
  logic        raw_forward = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [3:0]  new_state;
  logic [2:0]  report_kind;
  logic        forward_message;
  logic        forward_disconnect;
  logic [1:0]  fatal_notice;
  logic [1:0]  error_class;
  logic        id_mismatch;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  int          errors;
  int          pending;

  state_t      session_at = ST_NOTCONN;
  logic [63:0] tag_value = '0;
  logic        tag_known = 1'b0;
  int          calm_items = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  board_transfer_upstream_handshake dut (
    .clk(clk), .rst(rst),
    .event_valid(event_valid), .event_stall(event_stall),
    .operation(operation), .board_id(board_id), .raw_forward(raw_forward),
    .result_valid(result_valid), .result_stall(result_stall),
    .new_state(new_state), .report_kind(report_kind),
    .forward_message(forward_message), .forward_disconnect(forward_disconnect),
    .fatal_notice(fatal_notice), .error_class(error_class), .id_mismatch(id_mismatch),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  btuh_result_checker u_checker (
    .clk(clk), .rst(rst),
    .event_valid(event_valid), .event_stall(event_stall),
    .operation(operation), .board_id(board_id), .raw_forward(raw_forward),
    .result_valid(result_valid), .result_stall(result_stall),
    .new_state(new_state), .report_kind(report_kind),
    .forward_message(forward_message), .forward_disconnect(forward_disconnect),
    .fatal_notice(fatal_notice), .error_class(error_class), .id_mismatch(id_mismatch),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // receiver stalls: mostly short, some long, with calm stretches
  always @(posedge clk) begin : stall_gen
    int roll;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        result_stall <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else if (roll < 65) begin
        result_stall <= 1'b0;
        stall_left <= $urandom_range(40, 160);
      end else if (roll < 95) begin
        result_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        result_stall <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((event_valid && !event_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_board_transfer_upstream_handshake: FAIL");
      $finish;
    end
  end

  // Next session state for a legal in-session move, ST_DISC when not legal.
  function automatic state_t session_next(input state_t from, input logic [4:0] op);
    state_t to;
    to = ST_DISC;
    case (from)
      ST_NOTCONN: if (op == OP_P_CONNECT) to = ST_SOCKET;
      ST_SOCKET:  if (op == OP_L_SVCDESC) to = ST_SVCDESC;
      ST_SVCDESC: if (op == OP_P_SVCDESC) to = ST_IDLE;
      ST_IDLE:
        case (op)
          OP_L_READY:    to = ST_READY;
          OP_P_AVAIL:    to = ST_AVAIL;
          OP_P_FORECAST: to = ST_IDLE;
          default: ;
        endcase
      ST_AVAIL:
        case (op)
          OP_L_READY:  to = ST_AVRDY;
          OP_P_REVOKE: to = ST_IDLE;
          default: ;
        endcase
      ST_READY:
        case (op)
          OP_L_REVOKE:   to = ST_IDLE;
          OP_P_AVAIL:    to = ST_AVRDY;
          OP_L_START:    to = ST_TRANSP;
          OP_P_FORECAST: to = ST_READY;
          default: ;
        endcase
      ST_AVRDY:
        case (op)
          OP_L_REVOKE: to = ST_AVAIL;
          OP_P_REVOKE: to = ST_READY;
          OP_L_START:  to = ST_TRANSP;
          default: ;
        endcase
      ST_TRANSP:
        case (op)
          OP_L_STOP:     to = ST_STOPPED;
          OP_P_FINISHED: to = ST_FINISHED;
          OP_P_AVAIL, OP_P_REVOKE, OP_P_FORECAST: to = ST_TRANSP;
          default: ;
        endcase
      ST_STOPPED:
        case (op)
          OP_P_FINISHED: to = ST_IDLE;
          OP_P_AVAIL, OP_P_REVOKE, OP_P_FORECAST: to = ST_STOPPED;
          default: ;
        endcase
      ST_FINISHED: if (op == OP_L_STOP) to = ST_IDLE;
      default: ;
    endcase
    if (from != ST_NOTCONN && from != ST_DISC &&
        ((op >= OP_L_QUERY && op <= OP_L_ALIVE) || (op >= OP_P_BOARDINFO && op <= OP_P_ALIVE)))
      to = from;
    return to;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm_items = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 82) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input logic [4:0] op, input logic [63:0] bid, input logic raw);
    int     gap;
    state_t nxt;
    gap = pick_gap();
    if (gap != 0) begin
      event_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_valid <= 1'b1;
    operation <= op;
    board_id <= bid;
    raw_forward <= raw;
    do @(posedge clk); while (event_stall);
    nxt = session_next(session_at, op);
    if (op == OP_L_START) begin
      tag_known = (nxt != ST_DISC) && !raw;
      tag_value = bid;
    end
    if (nxt != ST_DISC) session_at = nxt;
  endtask

  task automatic wait_drained();
    event_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_strict(input logic value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] pass_through_op();
    if ($urandom_range(0, 1) != 0) return 5'($urandom_range(OP_L_QUERY, OP_L_ALIVE));
    return 5'($urandom_range(OP_P_BOARDINFO, OP_P_ALIVE));
  endfunction

  // one event that keeps the session alive; tolerated illegal locals when allowed
  task automatic session_item(input logic tolerant);
    logic [4:0]  op;
    logic [63:0] bid;
    logic        raw;
    int          roll;
    bid = {$urandom, $urandom};
    raw = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      do begin
        op = 5'($urandom_range(OP_L_SVCDESC, OP_P_FORECAST));
      end while (session_next(session_at, op) == ST_DISC);
      if (op == OP_P_FINISHED && tag_known) bid = tag_value;
    end else if (roll < 85 || (roll >= 90 && !tolerant)) begin
      op = pass_through_op();
    end else if (roll < 90) begin
      op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end else begin
      do begin
        op = 5'($urandom_range(OP_L_SVCDESC, OP_L_STOP));
      end while (session_next(session_at, op) != ST_DISC);
    end
    send(op, bid, raw);
  endtask

  initial begin : stimulus
    int         kill;
    logic [4:0] op;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // not connected, strict: unused and pass-through events are ignored
    send(OP_UNUSED_LO, '0, 1'b0);
    send(OP_UNUSED_HI, '1, 1'b1);
    send(OP_L_QUERY, '0, 1'b0);
    send(OP_P_ALIVE, '1, 1'b1);

    // tolerant: illegal locals warn and forward, then a full walk
    set_strict(1'b0);
    send(OP_L_SVCDESC, '0, 1'b0);
    send(OP_L_START, '1, 1'b0);
    send(OP_L_STOP, '0, 1'b1);
    send(OP_P_CONNECT, '0, 1'b0);
    send(OP_L_READY, '0, 1'b0);
    send(OP_L_SVCDESC, '0, 1'b0);
    send(OP_P_SVCDESC, '0, 1'b0);
    send(OP_L_READY, '0, 1'b0);
    send(OP_P_FORECAST, '0, 1'b0);
    send(OP_P_AVAIL, '0, 1'b0);
    send(OP_L_REVOKE, '0, 1'b0);
    send(OP_L_READY, '0, 1'b0);
    send(OP_P_REVOKE, '0, 1'b0);
    send(OP_L_START, '1, 1'b0);
    send(OP_P_AVAIL, '0, 1'b0);
    send(OP_L_STOP, '0, 1'b0);
    send(OP_P_FORECAST, '0, 1'b0);
    send(OP_P_FINISHED, '1, 1'b0);
    send(OP_P_AVAIL, '0, 1'b0);
    send(OP_L_READY, '0, 1'b0);
    send(OP_L_START, {$urandom, $urandom}, 1'b1);
    send(OP_P_FINISHED, '0, 1'b0);
    send(OP_L_NOTIFY, '0, 1'b0);
    send(OP_P_COMMAND, '0, 1'b0);
    send(OP_L_STOP, '0, 1'b0);

    set_strict(1'b1);
    repeat (600) begin
      if ($urandom_range(0, 199) == 0) wait_drained();
      session_item(1'b0);
    end

    set_strict(1'b0);
    repeat (560) begin
      if ($urandom_range(0, 199) == 0) wait_drained();
      session_item(1'b1);
    end

    // end the session with one disconnecting event, then noise while disconnected
    set_strict(1'b1);
    kill = $urandom_range(0, 5);
    if (kill <= 1) begin
      for (int n = 0; n < 300; n++) begin
        if (tag_known && (session_at == ST_TRANSP || session_at == ST_STOPPED)) break;
        session_item(1'b0);
      end
      if (tag_known && (session_at == ST_TRANSP || session_at == ST_STOPPED))
        send(OP_P_FINISHED, tag_value ^ (64'd1 << $urandom_range(0, 63)), 1'b0);
      else
        send(OP_P_CONNECT, {$urandom, $urandom}, 1'b0);
    end else if (kill == 2) begin
      send(OP_P_CONNECT, {$urandom, $urandom}, 1'b0);
    end else if (kill == 3) begin
      do begin
        op = 5'($urandom_range(OP_L_SVCDESC, OP_L_STOP));
      end while (session_next(session_at, op) != ST_DISC);
      send(op, {$urandom, $urandom}, 1'b0);
    end else if (kill == 4) begin
      send(OP_L_DISCONNECT, {$urandom, $urandom}, 1'b0);
    end else begin
      send(OP_P_DISCONN, {$urandom, $urandom}, 1'b0);
    end
    session_at = ST_DISC;

    repeat (130) send(5'($urandom_range(0, 31)), {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    set_strict(1'b0);
    repeat (130) send(5'($urandom_range(0, 31)), {$urandom, $urandom}, 1'($urandom_range(0, 1)));

    wait_drained();
    if (errors == 0 && pending == 0)
      $display("tb_board_transfer_upstream_handshake: PASS");
    else
      $display("tb_board_transfer_upstream_handshake: FAIL");
    $finish;
  end

endmodule

// ===== board_transfer_upstream_handshake.f =====
design/btuh_pkg.sv
design/btuh_step.sv
design/board_transfer_upstream_handshake.sv
dv/btuh_result_checker.sv
dv/tb_board_transfer_upstream_handshake.sv
